@@ hw/rtl/acfp_pkg.sv @@
// Types, codes and decode tables shared by the ASCII CAN frame parser.
`default_nettype none

package acfp_pkg;

  // Input word: one command character
  typedef struct packed {
    logic [7:0] character;
    logic       frame_start;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [28:0] frame_id;
    logic        extended_id;
    logic        remote_request;
    logic        fd_frame;
    logic        bit_rate_switch;
    logic [6:0]  payload_length;
    logic [7:0]  byte_value;
    logic [5:0]  byte_index;
    logic [1:0]  error_code;
    logic        last_item;
  } out_item_t;

  // Front-end classification of one character
  typedef struct packed {
    logic       start;    // first character of a command
    logic       cmd_ok;   // valid command letter
    logic [3:0] flags;    // format flags decoded from the command letter
    logic       hex_ok;   // character is a hex digit
    logic [3:0] nibble;   // its value
  } class_t;

  // Format flag bit positions
  localparam int unsigned FlagExt = 0;
  localparam int unsigned FlagRtr = 1;
  localparam int unsigned FlagFd  = 2;
  localparam int unsigned FlagBrs = 3;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_CMD  = 2'd0;
  localparam logic [1:0] ERR_ID   = 2'd1;
  localparam logic [1:0] ERR_DLC  = 2'd2;
  localparam logic [1:0] ERR_DATA = 2'd3;

  // Identifier digit counts
  localparam logic [3:0] EXT_DIGITS = 4'd8;
  localparam logic [3:0] STD_DIGITS = 4'd3;

  // Parser phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ID,
    PH_DLC,
    PH_DATA
  } phase_e;

  // DLC digit to payload byte count
  function automatic logic [6:0] dlc_length(input logic [3:0] dlc);
    logic [6:0] len;
    unique case (dlc)
      4'd9:    len = 7'd12;
      4'd10:   len = 7'd16;
      4'd11:   len = 7'd20;
      4'd12:   len = 7'd24;
      4'd13:   len = 7'd32;
      4'd14:   len = 7'd48;
      4'd15:   len = 7'd64;
      default: len = {3'd0, dlc};
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ascii_can_frame_parser_top.sv @@
// Top level of the ASCII CAN command parser: front end, queue and back end.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+----------------------------
//  in      | input     | in_valid_i/in_ready_o | acfp_pkg::in_item_t
//  out     | output    | out_valid_o/out_ready_i| acfp_pkg::out_item_t
//
// One character is accepted per cycle while the two-entry queue has room.
// An accepted character is written into the queue; the parser then decodes it
// from the queue and registers any result in the output register.
// The parser takes a queued character whenever the output register is empty
// or being read; a stalled output fills the queue and then drops in_ready_o.
// Reset (rst_ni low, asynchronous) empties the queue and puts the parser idle.
`default_nettype none

module ascii_can_frame_parser_top (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire                 logic in_valid_i,
  output logic                      in_ready_o,
  input  wire  acfp_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire                 logic out_ready_i,
  output acfp_pkg::out_item_t       out_data_o
);
  import acfp_pkg::*;

  logic   push;
  class_t push_data;
  logic   queue_full;
  logic   q_valid;
  logic   q_pop;
  class_t q_data;

  acfp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .queue_full_i (queue_full)
  );

  acfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  acfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/acfp_front.sv @@
// Front end: classifies each incoming character and hands it to the queue.
`default_nettype none

module acfp_front (
  input  wire                logic in_valid_i,
  output logic                     in_ready_o,
  input  wire  acfp_pkg::in_item_t in_data_i,
  output logic                     push_o,
  output acfp_pkg::class_t         push_data_o,
  input  wire                logic queue_full_i
);
  import acfp_pkg::*;

  logic [7:0] c;
  logic [7:0] upper;
  logic       is_upper;
  logic       is_lower;

  assign c        = in_data_i.character;
  assign is_upper = (c >= 8'h41) && (c <= 8'h5A);
  assign is_lower = (c >= 8'h61) && (c <= 8'h7A);
  assign upper    = (is_upper || is_lower) ? (c & 8'hDF) : 8'h00;

  // Command letter and hex digit decode
  always_comb begin
    push_data_o        = '0;
    push_data_o.start  = in_data_i.frame_start;
    push_data_o.flags[FlagExt] = is_upper;
    push_data_o.cmd_ok = 1'b1;
    unique case (upper)
      8'h42: begin // B
        push_data_o.flags[FlagFd]  = 1'b1;
        push_data_o.flags[FlagBrs] = 1'b1;
      end
      8'h44: push_data_o.flags[FlagFd]  = 1'b1; // D
      8'h52: push_data_o.flags[FlagRtr] = 1'b1; // R
      8'h54: ;                                  // T
      default: push_data_o.cmd_ok = 1'b0;
    endcase

    if ((c >= 8'h30) && (c <= 8'h39)) begin
      push_data_o.hex_ok = 1'b1;
      push_data_o.nibble = 4'(c - 8'h30);
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      push_data_o.hex_ok = 1'b1;
      push_data_o.nibble = 4'(c - 8'h37);
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      push_data_o.hex_ok = 1'b1;
      push_data_o.nibble = 4'(c - 8'h57);
    end
  end

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

endmodule

`default_nettype wire

@@ hw/rtl/acfp_queue.sv @@
// Two-entry queue of classified characters between front and back ends.
`default_nettype none

module acfp_queue (
  input  wire              logic clk_i,
  input  wire              logic rst_ni,
  input  wire              logic push_i,
  input  wire  acfp_pkg::class_t push_data_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire              logic pop_i,
  output acfp_pkg::class_t       pop_data_o
);
  import acfp_pkg::*;

  class_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/acfp_back.sv @@
// Back end: command parser state machine with the result output register.
`default_nettype none

module acfp_back (
  input  wire              logic  clk_i,
  input  wire              logic  rst_ni,
  input  wire              logic  q_valid_i,
  input  wire  acfp_pkg::class_t  q_data_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire              logic  out_ready_i,
  output acfp_pkg::out_item_t     out_data_o
);
  import acfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  flags_q, flags_d;
  logic [28:0] id_q, id_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [6:0]  len_q, len_d;
  logic [5:0]  done_q, done_d;
  logic [3:0]  hi_q, hi_d;
  logic        pend_q, pend_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        emit;
  out_item_t   res;
  logic [3:0]  need;
  logic [6:0]  next_idx;
  logic        is_last;

  // A word leaves the queue whenever the output register can take a result
  assign q_pop_o  = q_valid_i && (!out_valid_q || out_ready_i);
  assign need     = flags_q[FlagExt] ? EXT_DIGITS : STD_DIGITS;
  assign next_idx = {1'b0, done_q} + 7'd1;
  assign is_last  = (next_idx >= len_q);

  // Parser next state and result
  always_comb begin
    phase_d = phase_q;
    flags_d = flags_q;
    id_d    = id_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    done_d  = done_q;
    hi_d    = hi_q;
    pend_d  = pend_q;
    emit    = 1'b0;

    // Common frame fields
    res                 = '0;
    res.frame_id        = flags_q[FlagExt] ? id_q : {18'd0, id_q[10:0]};
    res.extended_id     = flags_q[FlagExt];
    res.remote_request  = flags_q[FlagRtr];
    res.fd_frame        = flags_q[FlagFd];
    res.bit_rate_switch = flags_q[FlagBrs];

    if (q_pop_o) begin
      if (q_data_i.start) begin
        if (q_data_i.cmd_ok) begin
          flags_d = q_data_i.flags;
          id_d    = '0;
          cnt_d   = '0;
          len_d   = '0;
          done_d  = '0;
          hi_d    = '0;
          pend_d  = 1'b0;
          phase_d = PH_ID;
        end else begin
          flags_d        = '0;
          id_d           = '0;
          len_d          = '0;
          emit           = 1'b1;
          res            = '0;
          res.item_kind  = KIND_ERROR;
          res.error_code = ERR_CMD;
          res.last_item  = 1'b1;
          phase_d        = PH_IDLE;
        end
      end else if (phase_q != PH_IDLE && !q_data_i.hex_ok) begin
        // Bad digit in any active phase
        emit           = 1'b1;
        res            = '0;
        res.item_kind  = KIND_ERROR;
        res.last_item  = 1'b1;
        phase_d        = PH_IDLE;
        unique case (phase_q)
          PH_ID:   res.error_code = ERR_ID;
          PH_DLC:  res.error_code = ERR_DLC;
          default: res.error_code = ERR_DATA;
        endcase
      end else begin
        unique case (phase_q)
          PH_ID: begin
            id_d  = {id_q[24:0], q_data_i.nibble};
            cnt_d = cnt_q + 4'd1;
            if (cnt_d >= need) begin
              phase_d = PH_DLC;
            end
          end
          PH_DLC: begin
            len_d              = dlc_length(q_data_i.nibble);
            done_d             = '0;
            pend_d             = 1'b0;
            emit               = 1'b1;
            res.item_kind      = KIND_HEADER;
            res.payload_length = len_d;
            res.last_item      = (len_d == 7'd0);
            phase_d            = (len_d == 7'd0) ? PH_IDLE : PH_DATA;
          end
          PH_DATA: begin
            if (!pend_q) begin
              hi_d   = q_data_i.nibble;
              pend_d = 1'b1;
            end else begin
              pend_d             = 1'b0;
              emit               = 1'b1;
              res.item_kind      = KIND_DATA;
              res.payload_length = len_q;
              res.byte_value     = {hi_q, q_data_i.nibble};
              res.byte_index     = done_q;
              res.last_item      = is_last;
              done_d             = done_q + 6'd1;
              if (is_last) begin
                phase_d = PH_IDLE;
              end
            end
          end
          default: ; // idle: characters without a start mark are dropped
        endcase
      end
    end

    // Output register
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      flags_q     <= '0;
      id_q        <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      done_q      <= '0;
      hi_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      flags_q     <= flags_d;
      id_q        <= id_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      done_q      <= done_d;
      hi_q        <= hi_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.item_kind == KIND_ERROR) |->
      (out_q.last_item && out_q.frame_id == '0 && out_q.payload_length == '0))
    else $error("error word carries frame fields");

  a_id_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ID) |-> (cnt_q < need))
    else $error("identifier digit count overran");

  a_data_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (len_q != '0 && {1'b0, done_q} < len_q))
    else $error("data byte position beyond payload length");
`endif

endmodule

`default_nettype wire

@@ tb/tb_ascii_can_frame_parser_top.sv @@
// Self-checking testbench for the ASCII CAN command parser top level.
`timescale 1ns / 100ps

module tb_ascii_can_frame_parser_top;
  import acfp_pkg::*;

  // Directed script line: one character, optionally with a hand-typed result
  typedef struct {
    in_item_t  chr;
    bit        typed;
    bit        has_word;
    out_item_t word;
  } script_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // Expected frame words, oldest first
  out_item_t   frames_q[$];
  script_row_t script_q[$];
  in_item_t    cmd_q[$];

  int err_count  = 0;
  int live_chars = 0;
  int burst_left = 0;
  int rx_cycle   = 0;
  int rx_mode    = 0;

  // Predicted parser state
  phase_e     parse_ph  = PH_IDLE;
  logic [3:0] fmt       = '0;
  logic [31:0] id_acc   = '0;
  logic [3:0] id_digits = '0;
  logic [6:0] pay_len   = '0;
  logic [6:0] bytes_seen = '0;
  logic [3:0] hi_nib    = '0;
  bit         nib_held  = 1'b0;

  ascii_can_frame_parser_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_item_t mk_in(input logic [7:0] c, input bit s);
    mk_in = {c, s};
  endfunction

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= "0" && c <= "9") v = 4'(c - "0");
    else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  // DLC digit to payload length
  function automatic logic [6:0] payload_bytes(input logic [3:0] dlc);
    case (dlc)
      4'd9:    payload_bytes = 7'd12;
      4'd10:   payload_bytes = 7'd16;
      4'd11:   payload_bytes = 7'd20;
      4'd12:   payload_bytes = 7'd24;
      4'd13:   payload_bytes = 7'd32;
      4'd14:   payload_bytes = 7'd48;
      4'd15:   payload_bytes = 7'd64;
      default: payload_bytes = {3'd0, dlc};
    endcase
  endfunction

  function automatic out_item_t err_word(input logic [1:0] code);
    out_item_t w;
    w = '0;
    w.item_kind  = KIND_ERROR;
    w.error_code = code;
    w.last_item  = 1'b1;
    return w;
  endfunction

  // Header/data word from the current frame state
  function automatic out_item_t frame_word(input logic [1:0] kind, input logic [7:0] val,
                                           input logic [5:0] idx, input bit last);
    out_item_t w;
    w = '0;
    w.item_kind       = kind;
    w.frame_id        = fmt[FlagExt] ? id_acc[28:0] : {18'd0, id_acc[10:0]};
    w.extended_id     = fmt[FlagExt];
    w.remote_request  = fmt[FlagRtr];
    w.fd_frame        = fmt[FlagFd];
    w.bit_rate_switch = fmt[FlagBrs];
    w.payload_length  = pay_len;
    w.byte_value      = val;
    w.byte_index      = idx;
    w.last_item       = last;
    return w;
  endfunction

  // Advance the predicted parser by one character
  task automatic decode_char(input in_item_t w, output bit produced, output out_item_t word,
                             output bit ignored);
    logic [7:0] c;
    logic [7:0] up;
    logic [3:0] nib;
    logic [3:0] fl;
    logic [1:0] code;
    bit         is_hex;
    bit         bad;
    bit         last;
    int         idx;
    c        = w.character;
    produced = 1'b0;
    ignored  = 1'b0;
    bad      = 1'b0;
    code     = ERR_CMD;
    word     = '0;
    is_hex   = hex_nibble(c, nib);
    if (w.frame_start) begin
      // command letter: restarts any frame in progress
      fl = '0;
      fl[FlagExt] = (c >= "A" && c <= "Z");
      up = ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) ? (c & 8'hDF) : 8'h00;
      case (up)
        "B":     begin fl[FlagFd] = 1'b1; fl[FlagBrs] = 1'b1; end
        "D":     fl[FlagFd] = 1'b1;
        "R":     fl[FlagRtr] = 1'b1;
        "T":     ;
        default: bad = 1'b1;
      endcase
      if (bad) begin
        fmt     = '0;
        id_acc  = '0;
        pay_len = '0;
      end else begin
        fmt        = fl;
        id_acc     = '0;
        id_digits  = '0;
        pay_len    = '0;
        bytes_seen = '0;
        hi_nib     = '0;
        nib_held   = 1'b0;
        parse_ph   = PH_ID;
      end
    end else begin
      case (parse_ph)
        PH_ID: begin
          if (!is_hex) begin
            bad  = 1'b1;
            code = ERR_ID;
          end else begin
            id_acc    = {id_acc[27:0], nib};
            id_digits = id_digits + 4'd1;
            if (id_digits >= (fmt[FlagExt] ? EXT_DIGITS : STD_DIGITS)) parse_ph = PH_DLC;
          end
        end
        PH_DLC: begin
          if (!is_hex) begin
            bad  = 1'b1;
            code = ERR_DLC;
          end else begin
            pay_len    = payload_bytes(nib);
            bytes_seen = '0;
            nib_held   = 1'b0;
            word       = frame_word(KIND_HEADER, 8'd0, 6'd0, pay_len == 0);
            produced   = 1'b1;
            parse_ph   = (pay_len == 0) ? PH_IDLE : PH_DATA;
          end
        end
        PH_DATA: begin
          if (!is_hex) begin
            bad  = 1'b1;
            code = ERR_DATA;
          end else if (!nib_held) begin
            hi_nib   = nib;
            nib_held = 1'b1;
          end else begin
            nib_held   = 1'b0;
            idx        = bytes_seen;
            last       = (idx + 1 >= pay_len);
            word       = frame_word(KIND_DATA, {hi_nib, nib}, idx[5:0], last);
            produced   = 1'b1;
            bytes_seen = bytes_seen + 7'd1;
            if (last) parse_ph = PH_IDLE;
          end
        end
        default: ignored = 1'b1;
      endcase
    end
    if (bad) begin
      word     = err_word(code);
      produced = 1'b1;
      parse_ph = PH_IDLE;
    end
  endtask

  // Offer one character in bursts; predict once it is taken
  task automatic send_char(input in_item_t w, output bit produced, output out_item_t word);
    bit ignored;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    decode_char(w, produced, word, ignored);
    if (!ignored) live_chars++;
  endtask

  // Hold off the sender until every expected word has come out
  task automatic drain_frames();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (frames_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 10) return "0" + d;
    return ($urandom_range(0, 1) ? "A" : "a") + d - 8'd10;
  endfunction

  function automatic script_row_t typed_row(input logic [7:0] c, input bit s, input bit has,
                                            input out_item_t w);
    script_row_t r;
    r.chr      = mk_in(c, s);
    r.typed    = 1'b1;
    r.has_word = has;
    r.word     = w;
    return r;
  endfunction

  // Characters checked by the predictor; first one opens a command
  task automatic add_plain(input string s);
    script_row_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.chr      = mk_in(s[i], i == 0);
      r.typed    = 1'b0;
      r.has_word = 1'b0;
      r.word     = '0;
      script_q.insert(script_q.size(), r);
    end
  endtask

  // One random command: mostly well formed, some broken, some noise
  task automatic build_command();
    string      letters;
    logic [7:0] c;
    logic [3:0] dlc;
    int         cut;
    letters = "BDRTbdrt";
    cmd_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      cmd_q.insert(cmd_q.size(), mk_in(8'($urandom_range(0, 255)), 1'b1));
    end else begin
      c = letters[$urandom_range(0, 7)];
      cmd_q.insert(cmd_q.size(), mk_in(c, 1'b1));
      repeat ((c >= "A" && c <= "Z") ? 8 : 3)
        cmd_q.insert(cmd_q.size(), mk_in(hex_char(4'($urandom_range(0, 15))), 1'b0));
      dlc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                        : 4'($urandom_range(0, 8));
      cmd_q.insert(cmd_q.size(), mk_in(hex_char(dlc), 1'b0));
      repeat (2 * payload_bytes(dlc))
        cmd_q.insert(cmd_q.size(), mk_in(hex_char(4'($urandom_range(0, 15))), 1'b0));
      // broken frame: cut short, then a stray character
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, cmd_q.size() - 1);
        while (cmd_q.size() > cut) void'(cmd_q.pop_back());
        cmd_q.insert(cmd_q.size(), mk_in(8'($urandom_range(0, 255)), 1'b0));
      end
    end
    // line noise between commands
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3))
        cmd_q.insert(cmd_q.size(), mk_in(8'($urandom_range(0, 255)), 1'b0));
  endtask

  task automatic flag_mismatch(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    err_count++;
  endtask

  // Output side: stall pattern and compare against the oldest expectation
  always @(posedge clk_i) begin : rx_side
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frames_q.size() == 0) begin
        $display("%0t: unexpected frame word, expected none, got %h", $time, out_data_o);
        err_count++;
      end else begin
        e = frames_q.pop_front();
        if (out_data_o.item_kind !== e.item_kind)
          flag_mismatch("item_kind", e.item_kind, out_data_o.item_kind);
        if (out_data_o.frame_id !== e.frame_id)
          flag_mismatch("frame_id", e.frame_id, out_data_o.frame_id);
        if (out_data_o.extended_id !== e.extended_id)
          flag_mismatch("extended_id", e.extended_id, out_data_o.extended_id);
        if (out_data_o.remote_request !== e.remote_request)
          flag_mismatch("remote_request", e.remote_request, out_data_o.remote_request);
        if (out_data_o.fd_frame !== e.fd_frame)
          flag_mismatch("fd_frame", e.fd_frame, out_data_o.fd_frame);
        if (out_data_o.bit_rate_switch !== e.bit_rate_switch)
          flag_mismatch("bit_rate_switch", e.bit_rate_switch, out_data_o.bit_rate_switch);
        if (out_data_o.payload_length !== e.payload_length)
          flag_mismatch("payload_length", e.payload_length, out_data_o.payload_length);
        if (out_data_o.byte_value !== e.byte_value)
          flag_mismatch("byte_value", e.byte_value, out_data_o.byte_value);
        if (out_data_o.byte_index !== e.byte_index)
          flag_mismatch("byte_index", e.byte_index, out_data_o.byte_index);
        if (out_data_o.error_code !== e.error_code)
          flag_mismatch("error_code", e.error_code, out_data_o.error_code);
        if (out_data_o.last_item !== e.last_item)
          flag_mismatch("last_item", e.last_item, out_data_o.last_item);
      end
    end
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((rx_cycle % 11) < 4);
    endcase
  end

  // Stimulus
  initial begin
    out_item_t hdr;
    out_item_t word;
    bit        produced;
    int        next_drain;

    // directed script
    hdr = '0;
    hdr.frame_id  = 29'h7FF;
    hdr.last_item = 1'b1;
    script_q.insert(script_q.size(), typed_row(8'hFF, 1'b1, 1'b1, err_word(ERR_CMD)));
    script_q.insert(script_q.size(), typed_row(8'h00, 1'b0, 1'b0, '0));
    script_q.insert(script_q.size(), typed_row(8'h0D, 1'b0, 1'b0, '0));
    add_plain("t7FF");
    // zero-length payload: header closes the frame
    script_q.insert(script_q.size(), typed_row("0", 1'b0, 1'b1, hdr));
    add_plain("B1fFFFFFF9a5");
    script_q.insert(script_q.size(), typed_row(":", 1'b0, 1'b1, err_word(ERR_DATA)));
    // restart in the middle of a frame
    add_plain("R1");
    add_plain("d000");
    script_q.insert(script_q.size(), typed_row("G", 1'b0, 1'b1, err_word(ERR_DLC)));
    add_plain("T");
    script_q.insert(script_q.size(), typed_row("z", 1'b0, 1'b1, err_word(ERR_ID)));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script_q[i]) begin
      send_char(script_q[i].chr, produced, word);
      if (script_q[i].typed) begin
        if (script_q[i].has_word) frames_q.insert(frames_q.size(), script_q[i].word);
      end else if (produced) begin
        frames_q.insert(frames_q.size(), word);
      end
    end
    drain_frames();

    // random commands
    next_drain = 500;
    while (live_chars < 1550) begin
      build_command();
      foreach (cmd_q[i]) begin
        send_char(cmd_q[i], produced, word);
        if (produced) frames_q.insert(frames_q.size(), word);
      end
      if (live_chars >= next_drain) begin
        drain_frames();
        next_drain += 500;
      end
    end

    drain_frames();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/acfp_pkg.sv
hw/rtl/acfp_front.sv
hw/rtl/acfp_queue.sv
hw/rtl/acfp_back.sv
hw/rtl/ascii_can_frame_parser_top.sv
tb/tb_ascii_can_frame_parser_top.sv
